@@ hdl/lattice_cell_neighbor_list_core_macros.svh @@
// assertion macros shared by the lattice neighbor list rtl
`ifndef LATTICE_CELL_NEIGHBOR_LIST_CORE_MACROS_SVH
`define LATTICE_CELL_NEIGHBOR_LIST_CORE_MACROS_SVH

// same-cycle implication
`define LCNL_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lcnl assertion failed");

// next-cycle implication
`define LCNL_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lcnl assertion failed");

`endif

@@ hdl/lcnl_pkg.sv @@
// types, codes and constants of the lattice neighbor list
package lcnl_pkg;

    localparam int MAX_PARTICLES_DEF = 1024;
    localparam int MAX_GRID_DIM_DEF  = 64;
    localparam int MAX_REACH_DEF     = 3;

    localparam int CMD_W      = 2;
    localparam int IDX_W      = 10;
    localparam int POS_W      = 32;
    localparam int GRID_W     = 7;
    localparam int REACH_W    = 2;
    localparam int COUNT_W    = 11;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD     = 2'd0,
        CMD_REFRESH  = 2'd1,
        CMD_PARTNERS = 2'd2,
        CMD_NOP      = 2'd3
    } cmd_t;

    localparam logic [CFG_IDX_W-1:0] REG_INV_CELL_SIZE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_REACH          = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_X          = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_Y          = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_PARTICLE_COUNT = 3'd6;

    typedef struct packed {
        logic [POS_W-1:0]   inv_cell_size;
        logic [GRID_W-1:0]  grid_width;
        logic [GRID_W-1:0]  grid_height;
        logic [REACH_W-1:0] reach;
        logic [POS_W-1:0]   box_x;
        logic [POS_W-1:0]   box_y;
        logic [COUNT_W-1:0] particle_count;
    } cfg_t;

endpackage

@@ hdl/lcnl_if.sv @@
// handshake channels of the lattice neighbor list
interface lcnl_req_if;
    import lcnl_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CMD_W-1:0]     command;
    logic [IDX_W-1:0]     particle_index;
    logic [POS_W-1:0]     pos_x;
    logic [POS_W-1:0]     pos_y;
    modport source (output valid, command, particle_index, pos_x, pos_y, input ready);
    modport sink (input valid, command, particle_index, pos_x, pos_y, output ready);
endinterface

interface lcnl_rsp_if;
    import lcnl_pkg::*;
    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] partner_index;
    logic             partner_valid;
    logic             list_updated;
    logic             last;
    modport source (output valid, partner_index, partner_valid, list_updated, last,
                    input ready);
    modport sink (input valid, partner_index, partner_valid, list_updated, last,
                  output ready);
endinterface

interface lcnl_cfg_if;
    import lcnl_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

@@ hdl/lattice_cell_neighbor_list_core.sv @@
// top level of the lattice neighbor list: configuration registers and sequencer
//
//  channel   dir  fields                                             transfer
//  cfg       in   index, data                                        valid & ready
//  request   in   command, particle_index, pos_x, pos_y              valid & ready
//  result    out  partner_index, partner_valid, list_updated, last   valid & ready
//
// load writes the position memory; partners walks the (2*reach+1)^2 cells around the particle
// a refresh check passes each particle through the shared multiplier and the
// lattice memory port; a rebuild adds a lattice clear of MAX_GRID_DIM*2^clog2(MAX_GRID_DIM)
// entries (4096 by default) plus an owner write per particle
// after reset the same clear runs before the request channel is ready
// a stalled result holds the sequencer only when a further result must be placed
module lattice_cell_neighbor_list_core #(
    parameter int MAX_PARTICLES = lcnl_pkg::MAX_PARTICLES_DEF,
    parameter int MAX_GRID_DIM  = lcnl_pkg::MAX_GRID_DIM_DEF,
    parameter int MAX_REACH     = lcnl_pkg::MAX_REACH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    lcnl_cfg_if.sink    cfg,
    lcnl_req_if.sink    request,
    lcnl_rsp_if.source  result
);
    import lcnl_pkg::*;

    cfg_t cfg_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.inv_cell_size  <= 32'd65536;
            cfg_reg.grid_width     <= 7'd64;
            cfg_reg.grid_height    <= 7'd64;
            cfg_reg.reach          <= 2'd1;
            cfg_reg.box_x          <= 32'd4194304;
            cfg_reg.box_y          <= 32'd4194304;
            cfg_reg.particle_count <= '0;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_INV_CELL_SIZE:  cfg_reg.inv_cell_size  <= cfg.data;
                REG_GRID_WIDTH:     cfg_reg.grid_width     <= cfg.data[GRID_W-1:0];
                REG_GRID_HEIGHT:    cfg_reg.grid_height    <= cfg.data[GRID_W-1:0];
                REG_REACH:          cfg_reg.reach          <= cfg.data[REACH_W-1:0];
                REG_BOX_X:          cfg_reg.box_x          <= cfg.data;
                REG_BOX_Y:          cfg_reg.box_y          <= cfg.data;
                REG_PARTICLE_COUNT: cfg_reg.particle_count <= cfg.data[COUNT_W-1:0];
                default:            cfg_reg                <= cfg_reg;
            endcase
        end
    end

    lcnl_seq #(
        .MAX_PARTICLES(MAX_PARTICLES),
        .MAX_GRID_DIM (MAX_GRID_DIM),
        .MAX_REACH    (MAX_REACH)
    ) u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_reg),
        .request(request),
        .result (result)
    );

endmodule

@@ hdl/lcnl_cell_unit.sv @@
// shared multiplier turning a position into a saturated cell number
module lcnl_cell_unit #(
    parameter int MAX_GRID_DIM = lcnl_pkg::MAX_GRID_DIM_DEF
) (
    input  logic                                  clk,
    input  logic                                  start,
    input  logic [lcnl_pkg::POS_W-1:0]            operand,
    input  logic [lcnl_pkg::POS_W-1:0]            scale,
    input  logic [$clog2(MAX_GRID_DIM+1)-1:0]     dim,
    output logic [$clog2(MAX_GRID_DIM)-1:0]       cell_num
);
    import lcnl_pkg::*;

    localparam int DW  = $clog2(MAX_GRID_DIM);
    localparam int DVW = $clog2(MAX_GRID_DIM + 1);

    logic [2*POS_W-1:0] prod_reg;
    logic [DVW-1:0]     dim_reg;
    logic [POS_W-1:0]   whole;

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            prod_reg <= (2*POS_W)'(operand) * (2*POS_W)'(scale);
            dim_reg  <= dim;
        end
    end

    // integer part of the product, clamped to the last cell
    assign whole    = prod_reg[2*POS_W-1:POS_W];
    assign cell_num = (whole >= POS_W'(dim_reg)) ? DW'(dim_reg - DVW'(1)) : whole[DW-1:0];

endmodule

@@ hdl/lcnl_seq.sv @@
// sequencer with position and lattice memories
`include "lattice_cell_neighbor_list_core_macros.svh"

module lcnl_seq #(
    parameter int MAX_PARTICLES = lcnl_pkg::MAX_PARTICLES_DEF,
    parameter int MAX_GRID_DIM  = lcnl_pkg::MAX_GRID_DIM_DEF,
    parameter int MAX_REACH     = lcnl_pkg::MAX_REACH_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  lcnl_pkg::cfg_t cfg,
    lcnl_req_if.sink       request,
    lcnl_rsp_if.source     result
);
    import lcnl_pkg::*;

    localparam int PW        = $clog2(MAX_PARTICLES);
    localparam int CW        = $clog2(MAX_PARTICLES + 1);
    localparam int DW        = $clog2(MAX_GRID_DIM);
    localparam int DVW       = $clog2(MAX_GRID_DIM + 1);
    localparam int OAW       = 2 * DW;
    localparam int OWN_DEPTH = MAX_GRID_DIM * (2 ** DW);
    localparam int SW        = $clog2(2 * MAX_REACH + 1);

    typedef enum logic [13:0] {
        S_CLEAR = 14'b00000000000001,
        S_IDLE  = 14'b00000000000010,
        S_POS   = 14'b00000000000100,
        S_MX    = 14'b00000000001000,
        S_MY    = 14'b00000000010000,
        S_CY    = 14'b00000000100000,
        S_ORD   = 14'b00000001000000,
        S_OCMP  = 14'b00000010000000,
        S_OWR   = 14'b00000100000000,
        S_WX    = 14'b00001000000000,
        S_WY    = 14'b00010000000000,
        S_NRD   = 14'b00100000000000,
        S_NCHK  = 14'b01000000000000,
        S_FIN   = 14'b10000000000000
    } state_t;

    typedef enum logic [1:0] {
        MODE_CHECK = 2'd0,
        MODE_BUILD = 2'd1,
        MODE_QUERY = 2'd2
    } mode_t;

    state_t state_reg, state_next;
    mode_t  mode_reg, mode_next;

    logic [CW-1:0]    i_reg, i_next;
    logic [IDX_W-1:0] q_reg, q_next;
    logic [DW-1:0]    cx_reg, cx_next, cy_reg, cy_next, cy0_reg, cy0_next;
    logic [SW-1:0]    a_reg, a_next, b_reg, b_next, k_reg, k_next;
    logic             inbox_reg, inbox_next;
    logic             pend_valid_reg, pend_valid_next;
    logic [IDX_W-1:0] pend_idx_reg, pend_idx_next;
    logic             fin_upd_reg, fin_upd_next;
    logic [OAW-1:0]   clr_reg, clr_next;

    logic             out_valid_reg, out_valid_next;
    logic [IDX_W-1:0] out_idx_reg, out_idx_next;
    logic             out_pv_reg, out_pv_next;
    logic             out_upd_reg, out_upd_next;
    logic             out_last_reg, out_last_next;

    // effective configuration
    logic [DVW-1:0] w_eff, h_eff;
    logic [DW-1:0]  wm1, hm1;
    logic [CW-1:0]  n_eff;
    logic [SW-1:0]  r_eff, two_r;

    // memories
    logic [POS_W-1:0] pos_x_mem [MAX_PARTICLES];
    logic [POS_W-1:0] pos_y_mem [MAX_PARTICLES];
    logic [PW:0]      owner_mem [OWN_DEPTH];
    logic [POS_W-1:0] pos_x_rd_reg, pos_y_rd_reg;
    logic [PW:0]      owner_rd_reg;

    logic             pos_we, pos_re;
    logic [PW-1:0]    pos_waddr, pos_raddr;
    logic             owner_we, owner_re;
    logic [OAW-1:0]   owner_waddr, owner_raddr;
    logic [PW:0]      owner_wdata;

    logic             unit_start;
    logic [POS_W-1:0] unit_op;
    logic [DVW-1:0]   unit_dim;
    logic [DW-1:0]    unit_cell;

    logic in_acc, out_free, push, hit;
    logic [IDX_W-1:0] push_idx;
    logic push_pv, push_upd, push_last;

    logic owner_wr_state, refresh_acc, refresh_next_ok;

    always_comb
    begin
        if (cfg.grid_width == '0)
            w_eff = DVW'(1);
        else if (32'(cfg.grid_width) > 32'(MAX_GRID_DIM))
            w_eff = DVW'(MAX_GRID_DIM);
        else
            w_eff = DVW'(cfg.grid_width);
        if (cfg.grid_height == '0)
            h_eff = DVW'(1);
        else if (32'(cfg.grid_height) > 32'(MAX_GRID_DIM))
            h_eff = DVW'(MAX_GRID_DIM);
        else
            h_eff = DVW'(cfg.grid_height);
        if (32'(cfg.particle_count) > 32'(MAX_PARTICLES))
            n_eff = CW'(MAX_PARTICLES);
        else
            n_eff = CW'(cfg.particle_count);
        if (32'(cfg.reach) > 32'(MAX_REACH))
            r_eff = SW'(MAX_REACH);
        else
            r_eff = SW'(cfg.reach);
    end

    assign wm1   = DW'(w_eff - DVW'(1));
    assign hm1   = DW'(h_eff - DVW'(1));
    assign two_r = SW'(r_eff << 1);

    assign in_acc        = request.valid && request.ready;
    assign request.ready = (state_reg == S_IDLE);
    assign out_free      = !out_valid_reg || result.ready;
    assign hit           = owner_rd_reg[PW] && (32'(owner_rd_reg[PW-1:0]) > 32'(q_reg));

    lcnl_cell_unit #(
        .MAX_GRID_DIM(MAX_GRID_DIM)
    ) u_cell (
        .clk     (clk),
        .start   (unit_start),
        .operand (unit_op),
        .scale   (cfg.inv_cell_size),
        .dim     (unit_dim),
        .cell_num(unit_cell)
    );

    always_comb
    begin
        state_next      = state_reg;
        mode_next       = mode_reg;
        i_next          = i_reg;
        q_next          = q_reg;
        cx_next         = cx_reg;
        cy_next         = cy_reg;
        cy0_next        = cy0_reg;
        a_next          = a_reg;
        b_next          = b_reg;
        k_next          = k_reg;
        inbox_next      = inbox_reg;
        pend_valid_next = pend_valid_reg;
        pend_idx_next   = pend_idx_reg;
        fin_upd_next    = fin_upd_reg;
        clr_next        = clr_reg;
        pos_we          = 1'b0;
        pos_waddr       = PW'(request.particle_index);
        pos_re          = 1'b0;
        pos_raddr       = (mode_reg == MODE_QUERY) ? PW'(q_reg) : i_reg[PW-1:0];
        owner_we        = 1'b0;
        owner_waddr     = {cx_reg, cy_reg};
        owner_wdata     = {1'b1, i_reg[PW-1:0]};
        owner_re        = 1'b0;
        owner_raddr     = {cx_reg, cy_reg};
        unit_start      = 1'b0;
        unit_op         = pos_x_rd_reg;
        unit_dim        = w_eff;
        push            = 1'b0;
        push_idx        = pend_idx_reg;
        push_pv         = 1'b1;
        push_upd        = 1'b0;
        push_last       = 1'b0;

        case (state_reg)
            S_CLEAR:
            begin
                owner_we    = 1'b1;
                owner_waddr = clr_reg;
                owner_wdata = '0;
                clr_next    = clr_reg + OAW'(1);
                if (clr_reg == OAW'(OWN_DEPTH - 1))
                begin
                    clr_next = '0;
                    i_next   = '0;
                    if (mode_reg == MODE_BUILD)
                        state_next = S_POS;
                    else
                        state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_acc)
                begin
                    case (request.command)
                        CMD_LOAD:
                        begin
                            pos_we = (32'(request.particle_index) < 32'(MAX_PARTICLES));
                        end
                        CMD_REFRESH:
                        begin
                            mode_next       = MODE_CHECK;
                            i_next          = '0;
                            fin_upd_next    = 1'b0;
                            pend_valid_next = 1'b0;
                            state_next      = (n_eff == '0) ? S_FIN : S_POS;
                        end
                        CMD_PARTNERS:
                        begin
                            mode_next       = MODE_QUERY;
                            q_next          = request.particle_index;
                            fin_upd_next    = 1'b0;
                            pend_valid_next = 1'b0;
                            if (32'(request.particle_index) < 32'(n_eff))
                                state_next = S_POS;
                            else
                                state_next = S_FIN;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_POS:
            begin
                pos_re     = 1'b1;
                state_next = S_MX;
            end
            S_MX:
            begin
                unit_start = 1'b1;
                inbox_next = (pos_x_rd_reg < cfg.box_x) && (pos_y_rd_reg < cfg.box_y);
                state_next = S_MY;
            end
            S_MY:
            begin
                unit_start = 1'b1;
                unit_op    = pos_y_rd_reg;
                unit_dim   = h_eff;
                cx_next    = unit_cell;
                state_next = S_CY;
            end
            S_CY:
            begin
                cy_next = unit_cell;
                k_next  = '0;
                case (mode_reg)
                    MODE_CHECK: state_next = S_ORD;
                    MODE_BUILD: state_next = S_OWR;
                    default:    state_next = inbox_reg ? S_WX : S_FIN;
                endcase
            end
            S_ORD:
            begin
                owner_re   = 1'b1;
                state_next = S_OCMP;
            end
            S_OCMP:
            begin
                if (owner_rd_reg != {1'b1, i_reg[PW-1:0]})
                begin
                    mode_next  = MODE_BUILD;
                    clr_next   = '0;
                    state_next = S_CLEAR;
                end
                else
                begin
                    i_next = i_reg + CW'(1);
                    if (i_reg + CW'(1) == n_eff)
                        state_next = S_FIN;
                    else
                        state_next = S_POS;
                end
            end
            S_OWR:
            begin
                owner_we = 1'b1;
                i_next   = i_reg + CW'(1);
                if (i_reg + CW'(1) == n_eff)
                begin
                    fin_upd_next = 1'b1;
                    mode_next    = MODE_CHECK;
                    state_next   = S_FIN;
                end
                else
                begin
                    state_next = S_POS;
                end
            end
            S_WX:
            begin
                // step left r cells with wrap
                if (k_reg == r_eff)
                begin
                    k_next     = '0;
                    state_next = S_WY;
                end
                else
                begin
                    cx_next = (cx_reg == '0) ? wm1 : cx_reg - DW'(1);
                    k_next  = k_reg + SW'(1);
                end
            end
            S_WY:
            begin
                if (k_reg == r_eff)
                begin
                    cy0_next   = cy_reg;
                    a_next     = '0;
                    b_next     = '0;
                    state_next = S_NRD;
                end
                else
                begin
                    cy_next = (cy_reg == '0) ? hm1 : cy_reg - DW'(1);
                    k_next  = k_reg + SW'(1);
                end
            end
            S_NRD:
            begin
                owner_re   = 1'b1;
                state_next = S_NCHK;
            end
            S_NCHK:
            begin
                if (!(hit && pend_valid_reg && !out_free))
                begin
                    if (hit)
                    begin
                        // earlier partner is now known not to be the last
                        push            = pend_valid_reg;
                        pend_idx_next   = IDX_W'(owner_rd_reg[PW-1:0]);
                        pend_valid_next = 1'b1;
                    end
                    if (b_reg == two_r)
                    begin
                        if (a_reg == two_r)
                        begin
                            state_next = S_FIN;
                        end
                        else
                        begin
                            a_next     = a_reg + SW'(1);
                            b_next     = '0;
                            cx_next    = (cx_reg == wm1) ? '0 : cx_reg + DW'(1);
                            cy_next    = cy0_reg;
                            state_next = S_NRD;
                        end
                    end
                    else
                    begin
                        b_next     = b_reg + SW'(1);
                        cy_next    = (cy_reg == hm1) ? '0 : cy_reg + DW'(1);
                        state_next = S_NRD;
                    end
                end
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    push       = 1'b1;
                    push_idx   = pend_valid_reg ? pend_idx_reg : '0;
                    push_pv    = pend_valid_reg;
                    push_upd   = fin_upd_reg;
                    push_last  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_idx_next  = out_idx_reg;
        out_pv_next   = out_pv_reg;
        out_upd_next  = out_upd_reg;
        out_last_next = out_last_reg;
        if (push)
        begin
            out_valid_next = 1'b1;
            out_idx_next   = push_idx;
            out_pv_next    = push_pv;
            out_upd_next   = push_upd;
            out_last_next  = push_last;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            mode_reg       <= MODE_CHECK;
            clr_reg        <= '0;
            i_reg          <= '0;
            k_reg          <= '0;
            a_reg          <= '0;
            b_reg          <= '0;
            pend_valid_reg <= 1'b0;
            fin_upd_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            mode_reg       <= mode_next;
            clr_reg        <= clr_next;
            i_reg          <= i_next;
            k_reg          <= k_next;
            a_reg          <= a_next;
            b_reg          <= b_next;
            pend_valid_reg <= pend_valid_next;
            fin_upd_reg    <= fin_upd_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg        <= q_next;
        cx_reg       <= cx_next;
        cy_reg       <= cy_next;
        cy0_reg      <= cy0_next;
        inbox_reg    <= inbox_next;
        pend_idx_reg <= pend_idx_next;
        out_idx_reg  <= out_idx_next;
        out_pv_reg   <= out_pv_next;
        out_upd_reg  <= out_upd_next;
        out_last_reg <= out_last_next;
    end

    always_ff @(posedge clk)
    begin
        if (pos_we)
        begin
            pos_x_mem[pos_waddr] <= request.pos_x;
            pos_y_mem[pos_waddr] <= request.pos_y;
        end
        if (pos_re)
        begin
            pos_x_rd_reg <= pos_x_mem[pos_raddr];
            pos_y_rd_reg <= pos_y_mem[pos_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (owner_we)
            owner_mem[owner_waddr] <= owner_wdata;
        if (owner_re)
            owner_rd_reg <= owner_mem[owner_raddr];
    end

    assign result.valid         = out_valid_reg;
    assign result.partner_index = out_idx_reg;
    assign result.partner_valid = out_pv_reg;
    assign result.list_updated  = out_upd_reg;
    assign result.last          = out_last_reg;

    assign owner_wr_state  = (state_reg == S_CLEAR) || (state_reg == S_OWR);
    assign refresh_acc     = in_acc && (request.command == CMD_REFRESH);
    assign refresh_next_ok = (state_reg == S_POS) || (state_reg == S_FIN);

    `LCNL_ASSERT_IMP(a_push_free, clk, rst_n, push, out_free)
    `LCNL_ASSERT_IMP(a_owner_write, clk, rst_n, owner_we, owner_wr_state)
    `LCNL_ASSERT_NXT(a_refresh_start, clk, rst_n, refresh_acc, refresh_next_ok)
    `LCNL_ASSERT_IMP(a_last_busy, clk, rst_n, push && push_last, state_reg == S_FIN)

endmodule
